[sv/pes_hp_pkg.sv]
// Package with the phase type, result kind codes and stream id helpers of the PES header parser.
`timescale 1ns / 1ps

package pes_hp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FIXED   = 2'd1,
        PH_OPT     = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_HEADER     = 2'd0;
    localparam kind_t KIND_PAYLOAD    = 2'd1;
    localparam kind_t KIND_BAD_PREFIX = 2'd2;

    localparam logic [7:0] SID_PROGRAM_MAP  = 8'hBC;
    localparam logic [7:0] SID_PADDING      = 8'hBE;
    localparam logic [7:0] SID_PRIVATE_2    = 8'hBF;
    localparam logic [7:0] SID_ECM          = 8'hF0;
    localparam logic [7:0] SID_EMM          = 8'hF1;
    localparam logic [7:0] SID_DSMCC        = 8'hF2;
    localparam logic [7:0] SID_H222_E       = 8'hF8;
    localparam logic [7:0] SID_DIRECTORY    = 8'hFF;

    localparam logic [23:0] START_CODE = 24'h000001;

    // True for stream ids whose packets carry the optional PES header.
    function automatic logic has_optional(input logic [7:0] id);
        has_optional = (id != SID_PROGRAM_MAP) && (id != SID_PADDING) &&
                       (id != SID_PRIVATE_2) && (id != SID_ECM) && (id != SID_EMM) &&
                       (id != SID_DSMCC) && (id != SID_H222_E) && (id != SID_DIRECTORY);
    endfunction

    // Reassembles a 33-bit time stamp from its five-byte coded form.
    function automatic logic [32:0] time_stamp(input logic [47:0] v);
        time_stamp = {v[35:33], v[31:17], v[15:1]};
    endfunction

endpackage

[sv/pes_header_parser_core.sv]
// Top level of the PES packet header parser: byte-wide parsing into a registered result.
// The result is registered: it appears on the m_ side in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register limits the rate only under stall.
// The parser state updates on each accepted byte; the result register updates with it when that byte emits a result.
// Reset (synchronous, aresetn low) returns the parser to idle, waiting for a first byte,
// and clears the result register's valid flag.
`timescale 1ns / 1ps

module pes_header_parser_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_first,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pes_hp_pkg::kind_t    m_kind,
    output logic [7:0]           m_stream_code,
    output logic [5:0]           m_media_flags,
    output logic [7:0]           m_option_flags,
    output logic [32:0]          m_pts,
    output logic [32:0]          m_dts,
    output logic [41:0]          m_escr,
    output logic [21:0]          m_es_rate,
    output logic [7:0]           m_trick_ctrl,
    output logic [15:0]          m_payload_length,
    output logic [7:0]           m_payload_byte,
    output logic                 m_last
);
    import pes_hp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [23:0] prefix_reg, prefix_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] plen_reg, plen_next;
    logic [5:0]  f1_reg, f1_next;
    logic [7:0]  f2_reg, f2_next;
    logic [7:0]  hdl_reg, hdl_next;
    logic [47:0] fs_reg, fs_next;
    logic [7:0]  cur_reg, cur_next;
    logic [32:0] pts_reg, pts_next;
    logic [32:0] dts_reg, dts_next;
    logic [41:0] escr_reg, escr_next;
    logic [21:0] rate_reg, rate_next;
    logic [7:0]  trick_reg, trick_next;
    logic [15:0] rem_reg, rem_next;

    logic        m_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  o_sid_reg;
    logic [5:0]  o_f1_reg;
    logic [7:0]  o_f2_reg;
    logic [32:0] o_pts_reg;
    logic [32:0] o_dts_reg;
    logic [41:0] o_escr_reg;
    logic [21:0] o_rate_reg;
    logic [7:0]  o_trick_reg;
    logic [15:0] o_plen_reg;
    logic [7:0]  o_byte_reg;
    logic        o_last_reg;

    logic        accept;
    logic        emit;
    kind_t       emit_kind;
    logic [15:0] emit_plen;
    logic        emit_last;

    logic [1:0]  ptsdts;
    logic [4:0]  o1, o2, o3, o4, o5;
    logic [8:0]  hdr_end;
    logic [8:0]  need;
    logic [7:0]  hdl_use;
    logic [15:0] start_plen;
    logic        do_start;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        prefix_next = prefix_reg;
        sid_next   = sid_reg;
        plen_next  = plen_reg;
        f1_next    = f1_reg;
        f2_next    = f2_reg;
        hdl_next   = hdl_reg;
        fs_next    = fs_reg;
        cur_next   = cur_reg;
        pts_next   = pts_reg;
        dts_next   = dts_reg;
        escr_next  = escr_reg;
        rate_next  = rate_reg;
        trick_next = trick_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        emit_kind  = KIND_HEADER;
        emit_plen  = '0;
        emit_last  = 1'b0;
        do_start   = 1'b0;
        start_plen = '0;
        hdl_use    = '0;
        hdr_end    = '0;
        need       = '0;

        // A first byte clears the packet state before the byte is parsed.
        if (s_first) begin
            phase_next  = PH_FIXED;
            pos_next    = '0;
            prefix_next = '0;
            sid_next    = '0;
            plen_next   = '0;
            f1_next     = '0;
            f2_next     = '0;
            hdl_next    = '0;
            fs_next     = '0;
            cur_next    = '0;
            pts_next    = '0;
            dts_next    = '0;
            escr_next   = '0;
            rate_next   = '0;
            trick_next  = '0;
            rem_next    = '0;
        end

        ptsdts = f2_next[7:6];
        o1 = ptsdts[1] ? 5'd5 : 5'd0;
        o2 = o1 + ((ptsdts == 2'b11) ? 5'd5 : 5'd0);
        o3 = o2 + (f2_next[5] ? 5'd6 : 5'd0);
        o4 = o3 + (f2_next[4] ? 5'd3 : 5'd0);
        o5 = o4 + (f2_next[3] ? 5'd1 : 5'd0);

        unique case (phase_next)
            PH_FIXED: begin
                pos_next = pos_next + 9'd1;
                if (pos_next < 9'd4) begin
                    prefix_next = {prefix_next[15:0], s_data_byte};
                    if (pos_next == 9'd3 && prefix_next != START_CODE) begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        emit_kind  = KIND_BAD_PREFIX;
                    end
                end else if (pos_next == 9'd4) begin
                    sid_next = s_data_byte;
                end else if (pos_next == 9'd5) begin
                    plen_next = {s_data_byte, 8'h00};
                end else begin
                    plen_next = {plen_next[15:8], s_data_byte};
                    if (has_optional(sid_next)) begin
                        phase_next = PH_OPT;
                    end else begin
                        emit      = 1'b1;
                        emit_kind = KIND_HEADER;
                        emit_plen = plen_next;
                        if (sid_next == SID_PADDING) begin
                            phase_next = PH_IDLE;
                        end else begin
                            do_start   = 1'b1;
                            start_plen = plen_next;
                        end
                    end
                end
            end
            PH_OPT: begin
                // After the increment, pos_next holds the position that follows this byte.
                pos_next = pos_next + 9'd1;
                if (pos_next == 9'd7) begin
                    f1_next = s_data_byte[5:0];
                end else if (pos_next == 9'd8) begin
                    f2_next = s_data_byte;
                end else begin
                    if (pos_next == 9'd9) begin
                        hdl_next = s_data_byte;
                    end else begin
                        fs_next = {fs_next[39:0], s_data_byte};
                        if (ptsdts[1] && cur_next == {3'd0, o1 - 5'd1}) begin
                            pts_next = time_stamp(fs_next);
                        end
                        if (ptsdts == 2'b11 && cur_next == {3'd0, o2 - 5'd1}) begin
                            dts_next = time_stamp(fs_next);
                        end
                        if (f2_next[5] && cur_next == {3'd0, o3 - 5'd1}) begin
                            escr_next = {fs_next[45:43], fs_next[41:27], fs_next[25:11],
                                         fs_next[9:1]};
                        end
                        if (f2_next[4] && cur_next == {3'd0, o4 - 5'd1}) begin
                            rate_next = fs_next[22:1];
                        end
                        if (f2_next[3] && cur_next == {3'd0, o5 - 5'd1}) begin
                            trick_next = s_data_byte;
                        end
                        cur_next = cur_next + 8'd1;
                    end
                    hdl_use = hdl_next;
                    hdr_end = 9'd9 + {1'b0, hdl_use};
                    if (pos_next == hdr_end) begin
                        need = 9'd3 + {1'b0, hdl_use};
                        if (plen_next != 16'd0 && plen_next >= {7'd0, need}) begin
                            start_plen = plen_next - {7'd0, need};
                        end
                        emit      = 1'b1;
                        emit_kind = KIND_HEADER;
                        emit_plen = start_plen;
                        do_start  = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                if (plen_next != 16'd0) begin
                    rem_next = rem_next - 16'd1;
                    if (rem_next == 16'd0) begin
                        emit_last  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_start) begin
            if (plen_next == 16'd0) begin
                phase_next = PH_PAYLOAD;
                rem_next   = '0;
            end else if (start_plen == 16'd0) begin
                phase_next = PH_IDLE;
            end else begin
                phase_next = PH_PAYLOAD;
                rem_next   = start_plen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            prefix_reg <= '0;
            sid_reg    <= '0;
            plen_reg   <= '0;
            f1_reg     <= '0;
            f2_reg     <= '0;
            hdl_reg    <= '0;
            fs_reg     <= '0;
            cur_reg    <= '0;
            pts_reg    <= '0;
            dts_reg    <= '0;
            escr_reg   <= '0;
            rate_reg   <= '0;
            trick_reg  <= '0;
            rem_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
            sid_reg    <= sid_next;
            plen_reg   <= plen_next;
            f1_reg     <= f1_next;
            f2_reg     <= f2_next;
            hdl_reg    <= hdl_next;
            fs_reg     <= fs_next;
            cur_reg    <= cur_next;
            pts_reg    <= pts_next;
            dts_reg    <= dts_next;
            escr_reg   <= escr_next;
            rate_reg   <= rate_next;
            trick_reg  <= trick_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            kind_reg    <= emit_kind;
            o_sid_reg   <= (emit_kind == KIND_BAD_PREFIX) ? 8'd0 : sid_next;
            o_byte_reg  <= (emit_kind == KIND_PAYLOAD) ? s_data_byte : 8'd0;
            o_last_reg  <= emit_last;
            o_plen_reg  <= emit_plen;
            if (emit_kind == KIND_HEADER) begin
                o_f1_reg    <= f1_next;
                o_f2_reg    <= f2_next;
                o_pts_reg   <= pts_next;
                o_dts_reg   <= dts_next;
                o_escr_reg  <= escr_next;
                o_rate_reg  <= rate_next;
                o_trick_reg <= trick_next;
            end else begin
                o_f1_reg    <= '0;
                o_f2_reg    <= '0;
                o_pts_reg   <= '0;
                o_dts_reg   <= '0;
                o_escr_reg  <= '0;
                o_rate_reg  <= '0;
                o_trick_reg <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_stream_code    = o_sid_reg;
    assign m_media_flags    = o_f1_reg;
    assign m_option_flags   = o_f2_reg;
    assign m_pts            = o_pts_reg;
    assign m_dts            = o_dts_reg;
    assign m_escr           = o_escr_reg;
    assign m_es_rate        = o_rate_reg;
    assign m_trick_ctrl     = o_trick_reg;
    assign m_payload_length = o_plen_reg;
    assign m_payload_byte   = o_byte_reg;
    assign m_last           = o_last_reg;

    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && o_last_reg |-> kind_reg == KIND_PAYLOAD)
        else $error("last mark on a result that is not a payload item");

    a_bad_prefix_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit && emit_kind == KIND_BAD_PREFIX |=> phase_reg == PH_IDLE)
        else $error("parser did not go idle after a bad start code");

    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit && emit_last |=> phase_reg == PH_IDLE)
        else $error("parser did not go idle after the last payload item");

    a_opt_within_header: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OPT |-> pos_reg <= 9'd8 + {1'b0, hdl_reg})
        else $error("optional header parsing ran past the header data area");

endmodule
